FILE: hdl/mfs_pkg.sv
// shared types and constants for the multilevel feedback scheduler
package mfs_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        OP_ADMIT    = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_REPORT   = 2'd2,
        OP_IO_DONE  = 2'd3
    } op_t;

    localparam logic [1:0] OC_EXHAUSTED = 2'd0;
    localparam logic [1:0] OC_WAIT_IO   = 2'd1;
    localparam logic [1:0] OC_FINISHED  = 2'd2;

    typedef enum logic [2:0] {
        RESP_DISPATCHED = 3'd0,
        RESP_NOTHING    = 3'd1,
        RESP_PARKED     = 3'd2,
        RESP_REJECTED   = 3'd3,
        RESP_ACCEPTED   = 3'd4
    } resp_t;

    typedef enum logic [2:0] {
        REG_QUANTUM_TOP    = 3'd0,
        REG_QUANTUM_MIDDLE = 3'd1,
        REG_QUANTUM_BOTTOM = 3'd2,
        REG_PASSES_TOP     = 3'd3,
        REG_PASSES_MIDDLE  = 3'd4,
        REG_PASSES_BOTTOM  = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [3:0] quantum_top;
        logic [3:0] quantum_middle;
        logic [3:0] quantum_bottom;
        logic [2:0] passes_top;
        logic [2:0] passes_middle;
        logic [2:0] passes_bottom;
    } cfg_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] task_id;
        logic [1:0] target_level;
        logic [1:0] outcome;
        logic [3:0] ticks_used;
    } cmd_t;

    typedef struct packed {
        resp_t      response;
        logic [7:0] out_task;
        logic [1:0] out_level;
        logic [3:0] out_quantum;
    } rsp_t;

endpackage

FILE: hdl/mfs_ram.sv
// generic single write port ram with registered read
module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/mfs_regs.sv
// apb configuration registers for quanta and pass limits
module mfs_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mfs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mfs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mfs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output mfs_pkg::cfg_t                  cfg
);

    mfs_pkg::cfg_t     cfg_reg;
    mfs_pkg::cfg_t     cfg_next;
    mfs_pkg::reg_idx_t idx;
    logic              wr;

    assign idx    = mfs_pkg::reg_idx_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                mfs_pkg::REG_QUANTUM_TOP:    cfg_next.quantum_top    = pwdata[3:0];
                mfs_pkg::REG_QUANTUM_MIDDLE: cfg_next.quantum_middle = pwdata[3:0];
                mfs_pkg::REG_QUANTUM_BOTTOM: cfg_next.quantum_bottom = pwdata[3:0];
                mfs_pkg::REG_PASSES_TOP:     cfg_next.passes_top     = pwdata[2:0];
                mfs_pkg::REG_PASSES_MIDDLE:  cfg_next.passes_middle  = pwdata[2:0];
                mfs_pkg::REG_PASSES_BOTTOM:  cfg_next.passes_bottom  = pwdata[2:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            mfs_pkg::REG_QUANTUM_TOP:    prdata = 32'(cfg_reg.quantum_top);
            mfs_pkg::REG_QUANTUM_MIDDLE: prdata = 32'(cfg_reg.quantum_middle);
            mfs_pkg::REG_QUANTUM_BOTTOM: prdata = 32'(cfg_reg.quantum_bottom);
            mfs_pkg::REG_PASSES_TOP:     prdata = 32'(cfg_reg.passes_top);
            mfs_pkg::REG_PASSES_MIDDLE:  prdata = 32'(cfg_reg.passes_middle);
            mfs_pkg::REG_PASSES_BOTTOM:  prdata = 32'(cfg_reg.passes_bottom);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quantum_top    <= 4'd1;
            cfg_reg.quantum_middle <= 4'd2;
            cfg_reg.quantum_bottom <= 4'd4;
            cfg_reg.passes_top     <= 3'd4;
            cfg_reg.passes_middle  <= 3'd2;
            cfg_reg.passes_bottom  <= 3'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/multilevel_feedback_scheduler_core.sv
// multilevel feedback queue scheduler top level
// Admit, report and io-done words are answered directly: the result word is registered
// at the edge that takes the command, and a new command can follow in the next cycle
// unless a stalled response holds it. A dispatch request with no task running walks the
// levels one per cycle (at most LEVELS+1 steps including one hold queue hand-over) and
// then reads the queue memory in the read state. All level queues and the hold queue
// share one ram of (LEVELS+1)*MAX_TASKS task ids with one write and one registered read
// port; the hold queue is handed to the bottom level by swapping regions, so no copy is
// made. The ram needs no clearing after reset.
module multilevel_feedback_scheduler_core #(
    parameter int MAX_TASKS = 256,
    parameter int LEVELS    = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mfs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mfs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mfs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  mfs_pkg::cmd_t                  cmd,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output mfs_pkg::rsp_t                  rsp
);

    localparam int NQ    = LEVELS + 1;
    localparam int QW    = $clog2(NQ);
    localparam int LW    = $clog2(LEVELS);
    localparam int HW    = $clog2(MAX_TASKS);
    localparam int CW    = $clog2(MAX_TASKS + 1);
    localparam int DEPTH = NQ * MAX_TASKS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [QW-1:0] HOLD_Q  = QW'(LEVELS);
    localparam logic [QW-1:0] BOT_Q   = QW'(LEVELS - 1);
    localparam logic [LW-1:0] BOT_L   = LW'(LEVELS - 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TASKS);

    mfs_pkg::cfg_t   cfg;
    mfs_pkg::state_t state_reg, state_next;

    logic [HW-1:0] head_reg  [NQ];
    logic [HW-1:0] head_next [NQ];
    logic [CW-1:0] count_reg [NQ];
    logic [CW-1:0] count_next[NQ];
    logic [LW-1:0] cur_reg, cur_next;
    logic [2:0]    pass_reg, pass_next;
    logic [LW-1:0] adv_reg, adv_next;
    logic [7:0]    run_task_reg, run_task_next;
    logic [LW-1:0] run_level_reg, run_level_next;
    logic          run_valid_reg, run_valid_next;
    logic          swap_reg, swap_next;
    mfs_pkg::rsp_t rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic          accept;
    logic          tlev_ok;
    logic [QW-1:0] push_q;
    logic          push_room;
    logic          do_push;
    logic [QW-1:0] cur_q;
    logic          scan_can;
    logic          scan_pop;
    logic          scan_drain;
    logic          scan_last;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    function automatic logic [3:0] quantum_of(input mfs_pkg::cfg_t c, input logic [LW-1:0] l);
        if (l == '0)
            return c.quantum_top;
        else if (l == BOT_L)
            return c.quantum_bottom;
        else
            return c.quantum_middle;
    endfunction

    function automatic logic [2:0] passes_of(input mfs_pkg::cfg_t c, input logic [LW-1:0] l);
        if (l == '0)
            return c.passes_top;
        else if (l == BOT_L)
            return c.passes_bottom;
        else
            return c.passes_middle;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic sw, input logic [QW-1:0] q,
                                              input logic [HW-1:0] i);
        logic [QW-1:0] region;
        region = q;
        if (sw && q == BOT_Q)
            region = HOLD_Q;
        else if (sw && q == HOLD_Q)
            region = BOT_Q;
        return AW'(region) * AW'(MAX_TASKS) + AW'(i);
    endfunction

    function automatic logic [HW-1:0] wrap_idx(input logic [HW-1:0] h, input logic [CW-1:0] n);
        logic [CW:0] sum;
        sum = (CW+1)'(h) + (CW+1)'(n);
        if (sum >= (CW+1)'(MAX_TASKS))
            sum = sum - (CW+1)'(MAX_TASKS);
        return sum[HW-1:0];
    endfunction

    mfs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mfs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (cmd.operation == mfs_pkg::OP_REPORT ? run_task_reg : cmd.task_id),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign cmd_stall = (state_reg != mfs_pkg::ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // push target for the current command
    assign tlev_ok = 32'(cmd.target_level) < LEVELS;

    always_comb
    begin
        push_q = '0;
        unique case (cmd.operation)
            mfs_pkg::OP_IO_DONE: push_q = tlev_ok ? QW'(cmd.target_level) : '0;
            mfs_pkg::OP_REPORT:  push_q = (run_level_reg == BOT_L) ? HOLD_Q
                                                               : QW'(run_level_reg) + QW'(1);
            default:             push_q = '0;
        endcase
    end

    assign push_room = count_reg[push_q] != MAX_CNT;

    // level walk
    assign cur_q      = QW'(cur_reg);
    assign scan_can   = pass_reg < passes_of(cfg, cur_reg);
    assign scan_pop   = scan_can && count_reg[cur_q] != '0;
    assign scan_drain = !scan_pop && scan_can && cur_reg == BOT_L && count_reg[HOLD_Q] != '0;
    assign scan_last  = adv_reg == BOT_L;
    assign rd_addr    = addr_of(swap_reg, cur_q, head_reg[cur_q]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mfs_pkg::ST_IDLE:
            begin
                if (accept && cmd.operation == mfs_pkg::OP_DISPATCH && !run_valid_reg)
                    state_next = mfs_pkg::ST_SCAN;
            end
            mfs_pkg::ST_SCAN:
            begin
                if (scan_pop)
                    state_next = mfs_pkg::ST_READ;
                else if (!scan_drain && scan_last)
                    state_next = mfs_pkg::ST_IDLE;
            end
            mfs_pkg::ST_READ:
            begin
                state_next = mfs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        pass_next      = pass_reg;
        adv_next       = adv_reg;
        run_task_next  = run_task_reg;
        run_level_next = run_level_reg;
        run_valid_next = run_valid_reg;
        swap_next      = swap_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        do_push        = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = addr_of(swap_reg, push_q, wrap_idx(head_reg[push_q], count_reg[push_q]));

        unique case (state_reg)
            mfs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.response    = mfs_pkg::RESP_REJECTED;
                    rsp_next.out_task    = '0;
                    rsp_next.out_level   = '0;
                    rsp_next.out_quantum = '0;
                    rsp_valid_next       = 1'b1;
                    unique case (cmd.operation)
                        mfs_pkg::OP_ADMIT, mfs_pkg::OP_IO_DONE:
                        begin
                            if (push_room && (tlev_ok || cmd.operation == mfs_pkg::OP_ADMIT))
                            begin
                                do_push            = 1'b1;
                                rsp_next.response  = mfs_pkg::RESP_ACCEPTED;
                                rsp_next.out_task  = cmd.task_id;
                                rsp_next.out_level = (cmd.operation == mfs_pkg::OP_IO_DONE)
                                                     ? cmd.target_level : 2'd0;
                            end
                        end
                        mfs_pkg::OP_DISPATCH:
                        begin
                            if (!run_valid_reg)
                            begin
                                rsp_valid_next = 1'b0;
                                adv_next       = '0;
                            end
                        end
                        mfs_pkg::OP_REPORT:
                        begin
                            if (run_valid_reg && cmd.outcome != 2'd3)
                            begin
                                run_valid_next    = 1'b0;
                                rsp_next.out_task = run_task_reg;
                                unique case (cmd.outcome)
                                    mfs_pkg::OC_EXHAUSTED:
                                    begin
                                        if (push_room)
                                        begin
                                            do_push            = 1'b1;
                                            rsp_next.response  = mfs_pkg::RESP_ACCEPTED;
                                            rsp_next.out_level = (run_level_reg == BOT_L)
                                                ? 2'(run_level_reg) : 2'(run_level_reg) + 2'd1;
                                        end
                                        else
                                        begin
                                            rsp_next.out_task = '0;
                                        end
                                    end
                                    mfs_pkg::OC_WAIT_IO:
                                    begin
                                        rsp_next.response = mfs_pkg::RESP_PARKED;
                                        if (cmd.ticks_used == quantum_of(cfg, run_level_reg))
                                            rsp_next.out_level = 2'(run_level_reg);
                                        else if (run_level_reg == '0)
                                            rsp_next.out_level = 2'd0;
                                        else
                                            rsp_next.out_level = 2'(run_level_reg) - 2'd1;
                                    end
                                    default:
                                    begin
                                        rsp_next.response  = mfs_pkg::RESP_ACCEPTED;
                                        rsp_next.out_level = 2'(run_level_reg);
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            mfs_pkg::ST_SCAN:
            begin
                if (scan_pop)
                begin
                    head_next[cur_q]  = (32'(head_reg[cur_q]) + 1 == MAX_TASKS)
                                        ? '0 : head_reg[cur_q] + HW'(1);
                    count_next[cur_q] = count_reg[cur_q] - CW'(1);
                    run_level_next    = cur_reg;
                    run_valid_next    = 1'b1;
                end
                else if (scan_drain)
                begin
                    // bottom queue is empty here: swap its region with the hold queue
                    swap_next          = !swap_reg;
                    head_next[BOT_Q]   = head_reg[HOLD_Q];
                    head_next[HOLD_Q]  = head_reg[BOT_Q];
                    count_next[BOT_Q]  = count_reg[HOLD_Q];
                    count_next[HOLD_Q] = '0;
                    pass_next          = pass_reg + 3'd1;
                end
                else
                begin
                    cur_next  = (cur_reg == BOT_L) ? '0 : cur_reg + LW'(1);
                    pass_next = '0;
                    adv_next  = adv_reg + LW'(1);
                    if (scan_last)
                    begin
                        rsp_next.response    = mfs_pkg::RESP_NOTHING;
                        rsp_next.out_task    = '0;
                        rsp_next.out_level   = '0;
                        rsp_next.out_quantum = '0;
                        rsp_valid_next       = 1'b1;
                    end
                end
            end
            mfs_pkg::ST_READ:
            begin
                run_task_next        = rd_data;
                rsp_next.response    = mfs_pkg::RESP_DISPATCHED;
                rsp_next.out_task    = rd_data;
                rsp_next.out_level   = 2'(run_level_reg);
                rsp_next.out_quantum = quantum_of(cfg, run_level_reg);
                rsp_valid_next       = 1'b1;
            end
            default:
            begin
                rsp_valid_next = rsp_valid_reg && rsp_stall;
            end
        endcase

        if (do_push)
        begin
            wr_en              = 1'b1;
            count_next[push_q] = count_reg[push_q] + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mfs_pkg::ST_IDLE;
            for (int i = 0; i < NQ; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            cur_reg       <= '0;
            pass_reg      <= '0;
            adv_reg       <= '0;
            run_task_reg  <= '0;
            run_level_reg <= '0;
            run_valid_reg <= 1'b0;
            swap_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            pass_reg      <= pass_next;
            adv_reg       <= adv_next;
            run_task_reg  <= run_task_next;
            run_level_reg <= run_level_next;
            run_valid_reg <= run_valid_next;
            swap_reg      <= swap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != mfs_pkg::ST_IDLE |-> cmd_stall)
        else $error("command taken while a dispatch is in progress");

    a_scan_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mfs_pkg::ST_SCAN |-> !run_valid_reg)
        else $error("level walk with a task running");

    a_read_gives_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mfs_pkg::ST_READ |=>
            rsp_valid_reg && rsp_reg.response == mfs_pkg::RESP_DISPATCHED && run_valid_reg)
        else $error("queue read did not produce a dispatch word");

    a_dispatch_running: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.response == mfs_pkg::RESP_DISPATCHED |-> run_valid_reg)
        else $error("dispatch word without a running task");

endmodule
